### hw/rtl/bhsv_pkg.sv
// ============================================================================
// bhsv_pkg
// Shared types and constants for the pixel color space converter.
// ============================================================================
package bhsv_pkg;

   localparam int PIX_W = 8;

   // Hue quotient 60*|diff|/d never exceeds 60; keep it at pixel width so
   // the hue divider has as many stages as the saturation divider
   localparam int HQUO_W = 8;
   localparam int HNUM_W = 14;
   localparam int SNUM_W = 16;

   // Sector of the largest channel
   typedef logic [1:0] sector_type;
   localparam sector_type SEC_BLUE  = 2'd0;
   localparam sector_type SEC_GREEN = 2'd1;
   localparam sector_type SEC_RED   = 2'd2;

   localparam logic signed [9:0] HUE_BASE_BLUE  = 10'sd240;
   localparam logic signed [9:0] HUE_BASE_GREEN = 10'sd120;
   localparam logic signed [9:0] HUE_BASE_RED   = 10'sd0;
   localparam logic signed [9:0] HUE_FULL_TURN  = 10'sd360;

   // Side data that travels with the hue division
   typedef struct packed {
      logic       grey;
      logic       neg;
      sector_type sector;
   } hue_side_type;

   // Side data that travels with the saturation division
   typedef struct packed {
      logic             vzero;
      logic [PIX_W-1:0] vmax;
   } sat_side_type;

endpackage

### hw/rtl/bhsv_div_pipe.sv
// ============================================================================
// bhsv_div_pipe
// Pipelined restoring divider: a few quotient bits per stage, with a common
// stage enable and side data carried alongside each item.
// ============================================================================
module bhsv_div_pipe #(
   parameter int NUM_W  = 16,
   parameter int DEN_W  = 8,
   parameter int QUO_W  = 8,
   parameter int STEP_N = 2,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en_i,
   input  logic              valid_i,
   input  logic [NUM_W-1:0]  num_i,
   input  logic [DEN_W-1:0]  den_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic              valid_o,
   output logic [QUO_W-1:0]  quo_o,
   output logic              rem_nz_o,
   output logic [SIDE_W-1:0] side_o
);

   localparam int STAGES = (QUO_W + STEP_N - 1) / STEP_N;
   localparam int CMP_W  = NUM_W + DEN_W;

   logic              valid_ff [STAGES];
   logic [NUM_W-1:0]  rem_ff   [STAGES];
   logic [QUO_W-1:0]  quo_ff   [STAGES];
   logic [DEN_W-1:0]  den_ff   [STAGES];
   logic [SIDE_W-1:0] side_ff  [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic              valid_k;
      logic [DEN_W-1:0]  den_k;
      logic [SIDE_W-1:0] side_k;
      logic [NUM_W-1:0]  rem_c [STEP_N+1];
      logic [QUO_W-1:0]  quo_c [STEP_N+1];
      logic [NUM_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      // Select stage input: module ports for the first stage
      if (k == 0) begin : g_first
         assign valid_k  = valid_i;
         assign den_k    = den_i;
         assign side_k   = side_i;
         assign rem_c[0] = num_i;
         assign quo_c[0] = '0;
      end else begin : g_next
         assign valid_k  = valid_ff[k-1];
         assign den_k    = den_ff[k-1];
         assign side_k   = side_ff[k-1];
         assign rem_c[0] = rem_ff[k-1];
         assign quo_c[0] = quo_ff[k-1];
      end

      // Trial subtract of the shifted divisor, one quotient bit a step
      for (genvar j = 0; j < STEP_N; j++) begin : g_step
         localparam int BIT = QUO_W - 1 - (k * STEP_N + j);
         if (BIT >= 0) begin : g_live
            logic [CMP_W-1:0] trial;
            logic             fits;
            assign trial = CMP_W'(den_k) << BIT;
            assign fits  = CMP_W'(rem_c[j]) >= trial;
            assign rem_c[j+1] = fits ? rem_c[j] - trial[NUM_W-1:0] : rem_c[j];
            assign quo_c[j+1] = quo_c[j] | (QUO_W'(fits) << BIT);
         end else begin : g_idle
            assign rem_c[j+1] = rem_c[j];
            assign quo_c[j+1] = quo_c[j];
         end
      end

      assign rem_in = rem_c[STEP_N];
      assign quo_in = quo_c[STEP_N];

      // Advance the stage when the pipeline is enabled
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en_i) begin
            valid_ff[k] <= valid_k;
         end
      end

      always_ff @(posedge clock) begin
         if (en_i) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= den_k;
            side_ff[k] <= side_k;
         end
      end
   end

   assign valid_o  = valid_ff[STAGES-1];
   assign quo_o    = quo_ff[STAGES-1];
   assign rem_nz_o = |rem_ff[STAGES-1];
   assign side_o   = side_ff[STAGES-1];

endmodule

### hw/rtl/bgr_to_hsv_pixel.sv
// ============================================================================
// bgr_to_hsv_pixel
// Converts one 8-bit blue, green, red pixel to half-degree hue, saturation
// and value, one pixel per clock while req_tready is high.
// ============================================================================
//
//   channel | direction | tdata fields (low bit up)            | tuser
//   --------+-----------+--------------------------------------+------
//   req_    | in        | blue[7:0] green[15:8] red[23:16]     | none
//   rsp_    | out       | hue[7:0] saturation[15:8] value[23:16] | none
//
// One pixel accepted per clock while req_tready is high; from acceptance to
// rsp_tvalid a pixel passes the min/max stage, numerator stage, four divider stages
// at two quotient bits each, and the output register.
// Reset clears only the valid bits and the skid entry.
// A stall on rsp_ fills a one-entry skid register; req_tready drops, from a
// register, only once the skid is full, and the whole pipeline then holds.
//
module bgr_to_hsv_pixel
   import bhsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // blue[7:0], green[15:8], red[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // hue[7:0], saturation[15:8], brightness[23:16]
);

   localparam int DIV_STEP = 2;

   logic             en;
   logic [PIX_W-1:0] in_b, in_g, in_r;

   assign in_b = req_tdata[7:0];
   assign in_g = req_tdata[15:8];
   assign in_r = req_tdata[23:16];

   // ------------------------------------------------------------------
   // Stage A: channel max/min, sector, and the three pair differences
   // ------------------------------------------------------------------
   logic             a_valid_ff;
   logic [PIX_W-1:0] a_vmax_ff, a_vmin_ff;
   sector_type       a_sector_ff;
   logic [PIX_W-1:0] a_mag_rg_ff, a_mag_br_ff, a_mag_gb_ff;
   logic             a_neg_rg_ff, a_neg_br_ff, a_neg_gb_ff;

   logic [PIX_W-1:0] a_vmax_in, a_vmin_in;
   sector_type       a_sector_in;
   logic [PIX_W:0]   dif_rg, dif_br, dif_gb;

   always_comb begin
      a_vmax_in   = in_b;
      a_sector_in = SEC_BLUE;
      if (in_g > a_vmax_in) begin
         a_vmax_in   = in_g;
         a_sector_in = SEC_GREEN;
      end
      if (in_r > a_vmax_in) begin
         a_vmax_in   = in_r;
         a_sector_in = SEC_RED;
      end
      a_vmin_in = in_b;
      if (in_g < a_vmin_in) a_vmin_in = in_g;
      if (in_r < a_vmin_in) a_vmin_in = in_r;
   end

   assign dif_rg = {1'b0, in_r} - {1'b0, in_g};
   assign dif_br = {1'b0, in_b} - {1'b0, in_r};
   assign dif_gb = {1'b0, in_g} - {1'b0, in_b};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_vmax_ff   <= a_vmax_in;
         a_vmin_ff   <= a_vmin_in;
         a_sector_ff <= a_sector_in;
         a_neg_rg_ff <= dif_rg[PIX_W];
         a_neg_br_ff <= dif_br[PIX_W];
         a_neg_gb_ff <= dif_gb[PIX_W];
         a_mag_rg_ff <= dif_rg[PIX_W] ? PIX_W'(-dif_rg) : dif_rg[PIX_W-1:0];
         a_mag_br_ff <= dif_br[PIX_W] ? PIX_W'(-dif_br) : dif_br[PIX_W-1:0];
         a_mag_gb_ff <= dif_gb[PIX_W] ? PIX_W'(-dif_gb) : dif_gb[PIX_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Stage B: range, sector difference and both numerators
   // ------------------------------------------------------------------
   logic              b_valid_ff;
   logic [SNUM_W-1:0] b_snum_ff;
   logic [HNUM_W-1:0] b_hnum_ff;
   logic [PIX_W-1:0]  b_d_ff;
   sat_side_type      b_sside_ff;
   hue_side_type      b_hside_ff;

   logic [PIX_W-1:0]  b_d_in, sel_mag;
   logic              sel_neg;

   assign b_d_in = a_vmax_ff - a_vmin_ff;

   always_comb begin
      case (a_sector_ff)
         SEC_BLUE: begin
            sel_mag = a_mag_rg_ff;
            sel_neg = a_neg_rg_ff;
         end
         SEC_GREEN: begin
            sel_mag = a_mag_br_ff;
            sel_neg = a_neg_br_ff;
         end
         default: begin
            sel_mag = a_mag_gb_ff;
            sel_neg = a_neg_gb_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   // 255*d as d*256 - d, 60*m as m*64 - m*4
   always_ff @(posedge clock) begin
      if (en) begin
         b_snum_ff         <= (SNUM_W'(b_d_in) << 8) - SNUM_W'(b_d_in);
         b_hnum_ff         <= (HNUM_W'(sel_mag) << 6) - (HNUM_W'(sel_mag) << 2);
         b_d_ff            <= b_d_in;
         b_sside_ff.vzero  <= (a_vmax_ff == '0);
         b_sside_ff.vmax   <= a_vmax_ff;
         b_hside_ff.grey   <= (b_d_in == '0);
         b_hside_ff.neg    <= sel_neg;
         b_hside_ff.sector <= a_sector_ff;
      end
   end

   // ------------------------------------------------------------------
   // Dividers: saturation 255*d/V and hue offset 60*|diff|/d
   // ------------------------------------------------------------------
   logic             sdiv_valid, hdiv_valid;
   logic [PIX_W-1:0] sdiv_quo;
   logic [HQUO_W-1:0] hdiv_quo;
   logic             hdiv_rem_nz;
   sat_side_type     sdiv_side;
   hue_side_type     hdiv_side;

   bhsv_div_pipe #(
      .NUM_W  (SNUM_W),
      .DEN_W  (PIX_W),
      .QUO_W  (PIX_W),
      .STEP_N (DIV_STEP),
      .SIDE_W ($bits(sat_side_type))
   ) u_sat_div (
      .clock    (clock),
      .reset    (reset),
      .en_i     (en),
      .valid_i  (b_valid_ff),
      .num_i    (b_snum_ff),
      .den_i    (b_sside_ff.vmax),
      .side_i   (b_sside_ff),
      .valid_o  (sdiv_valid),
      .quo_o    (sdiv_quo),
      .rem_nz_o (),
      .side_o   (sdiv_side)
   );

   bhsv_div_pipe #(
      .NUM_W  (HNUM_W),
      .DEN_W  (PIX_W),
      .QUO_W  (HQUO_W),
      .STEP_N (DIV_STEP),
      .SIDE_W ($bits(hue_side_type))
   ) u_hue_div (
      .clock    (clock),
      .reset    (reset),
      .en_i     (en),
      .valid_i  (b_valid_ff),
      .num_i    (b_hnum_ff),
      .den_i    (b_d_ff),
      .side_i   (b_hside_ff),
      .valid_o  (hdiv_valid),
      .quo_o    (hdiv_quo),
      .rem_nz_o (hdiv_rem_nz),
      .side_o   (hdiv_side)
   );

   // ------------------------------------------------------------------
   // Final hue: sign, floor or truncate, sector base, wrap and halve
   // ------------------------------------------------------------------
   logic signed [9:0] h_mag, h_off, h_base, h_raw, h_wrap;
   logic              floor_adj;
   logic [PIX_W-1:0]  fin_hue, fin_sat;
   logic [23:0]       fin_data;

   assign h_mag     = signed'(10'(hdiv_quo));
   assign floor_adj = hdiv_rem_nz && (hdiv_side.sector != SEC_RED);
   assign h_off     = hdiv_side.neg ? (-h_mag - signed'(10'(floor_adj))) : h_mag;

   always_comb begin
      case (hdiv_side.sector)
         SEC_BLUE:  h_base = HUE_BASE_BLUE;
         SEC_GREEN: h_base = HUE_BASE_GREEN;
         default:   h_base = HUE_BASE_RED;
      endcase
   end

   assign h_raw    = h_base + h_off;
   assign h_wrap   = (h_raw < 0) ? h_raw + HUE_FULL_TURN : h_raw;
   assign fin_hue  = hdiv_side.grey ? '0 : h_wrap[8:1];
   assign fin_sat  = sdiv_side.vzero ? '0 : sdiv_quo;
   assign fin_data = {sdiv_side.vmax, fin_sat, fin_hue};

   // ------------------------------------------------------------------
   // Output register with one-entry skid
   // ------------------------------------------------------------------
   logic        out_valid_ff, skid_valid_ff;
   logic [23:0] out_data_ff, skid_data_ff;
   logic        push, take;

   assign en         = !skid_valid_ff;
   assign req_tready = !skid_valid_ff;
   assign push       = en && hdiv_valid;
   assign take       = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) skid_valid_ff <= 1'b0;
      end else if (push) begin
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) out_data_ff <= skid_data_ff;
      end else if (push) begin
         if (out_valid_ff && !take) begin
            skid_data_ff <= fin_data;
         end else begin
            out_data_ff <= fin_data;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef NO_ASSERTIONS
   // Skid entry is only ever filled behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output valid");

   // Both dividers carry the same items in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      sdiv_valid == hdiv_valid)
      else $error("divider valid bits out of step");

   // Hue in half degrees stays within one full turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] < 8'd180))
      else $error("hue out of range");

   // Black pixel gives zero hue and saturation
   a_black_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[23:16] == 8'd0)) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("black pixel with nonzero hue or saturation");

   // A full skid is drained into the output when the result is taken
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry not drained");
`endif

endmodule
